@@ sv/log9_pkg.sv @@
`timescale 1ns / 1ps
// log9_pkg: shared widths, kernel table, control struct and helpers for the
// 9x9 LoG luma filter. No dependencies.
package log9_pkg;

  localparam int KR      = 4;            // kernel radius
  localparam int KS      = 2 * KR + 1;   // kernel size
  localparam int LW      = 18;           // scaled luma width
  localparam int EW      = 27;           // energy width
  localparam int PW      = 8;            // color component width
  localparam int RW      = 12;           // output row width
  localparam int HW      = 13;           // effective height width
  localparam int WRW     = 11;           // image_width register width
  localparam int CFG_W   = 13;           // config data width
  localparam int CFG_IW  = 1;            // config index width
  localparam int SLW     = 4;            // ring slot index width
  localparam int EIW     = 2;            // left edge cache index width
  localparam int H_MAX   = 4096;
  localparam int H_RESET = 768;
  localparam int W_RESET = 1024;

  localparam logic signed [EW-1:0] ENERGY_OFFSET = 27'sd14096;

  localparam logic [LW-1:0] LUMA_R = 18'd306;
  localparam logic [LW-1:0] LUMA_G = 18'd601;
  localparam logic [LW-1:0] LUMA_B = 18'd117;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int KERNEL [KS][KS] = '{
    '{0, 1, 1,   2,   2,   2, 1, 1, 0},
    '{1, 2, 4,   5,   5,   5, 4, 2, 1},
    '{1, 4, 5,   3,   0,   3, 5, 4, 1},
    '{2, 5, 3, -12, -24, -12, 3, 5, 2},
    '{2, 5, 0, -24, -40, -24, 0, 5, 2},
    '{2, 5, 3, -12, -24, -12, 3, 5, 2},
    '{1, 4, 5,   3,   0,   3, 5, 4, 1},
    '{1, 2, 4,   5,   5,   5, 4, 2, 1},
    '{0, 1, 1,   2,   2,   2, 1, 1, 0}
  };

  // per-cell control for one step
  typedef struct packed {
    logic                       hit;         // write lands in this cell
    logic                       emit;        // a result is formed this step
    logic [KS-1:1]              from_shift;  // tap j comes from the shift line
    logic [KS-1:1][EIW-1:0]     edge_idx;    // else from the left edge cache
  } cell_ctl_t;

  function automatic logic [LW-1:0] luma_of(input logic [PW-1:0] r,
                                            input logic [PW-1:0] g,
                                            input logic [PW-1:0] b);
    return LUMA_R * LW'(r) + LUMA_G * LW'(g) + LUMA_B * LW'(b);
  endfunction

  // (s + off) mod KS for s in 0..KS-1 and |off| < KS
  function automatic logic [SLW-1:0] slot_add(input logic [SLW-1:0] s, input int off);
    int t;
    t = int'(s) + off;
    if (t < 0) t = t + KS;
    else if (t >= KS) t = t - KS;
    return SLW'(t);
  endfunction

  function automatic logic signed [EW-1:0] weigh(input logic [LW-1:0] l, input int wgt);
    return $signed({(EW-LW)'(0), l}) * EW'(wgt);
  endfunction

endpackage

@@ sv/log9_cell.sv @@
`timescale 1ns / 1ps
// log9_cell: one ring slot of the line store with its column shift line and
// left edge cache, kept coherent by snooping writes. Depends on log9_pkg.
module log9_cell #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                        clk,
  input  log9_pkg::cell_ctl_t                         ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]                wr_col,
  input  logic [log9_pkg::LW-1:0]                     wr_data,
  input  logic [$clog2(MAX_WIDTH)-1:0]                fetch_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]                rd_addr,
  output logic [log9_pkg::KS-1:0][log9_pkg::LW-1:0]   taps
);
  import log9_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [LW-1:0] mem [MAX_WIDTH];
  logic [LW-1:0] rd_q;
  logic [LW-1:0] sh_r   [1:KS-1];
  logic [LW-1:0] sh_nxt [1:KS-1];
  logic [LW-1:0] sh_eff [1:KS-1];
  logic [CW-1:0] tag_r   [1:KS-1];
  logic [CW-1:0] tag_nxt [1:KS-1];
  logic [LW-1:0] edge_r   [KR];
  logic [LW-1:0] edge_nxt [KR];
  logic [LW-1:0] fetch_eff;

  always_comb begin
    // current step's write is seen before the window is formed
    fetch_eff = (ctl.hit && wr_col == fetch_col) ? wr_data : rd_q;
    for (int j = 1; j < KS; j++) begin
      sh_eff[j] = (ctl.hit && wr_col == tag_r[j]) ? wr_data : sh_r[j];
    end
    for (int k = 0; k < KR; k++) begin
      edge_nxt[k] = (ctl.hit && wr_col == CW'(k)) ? wr_data : edge_r[k];
    end
    if (ctl.emit) begin
      sh_nxt[1]  = fetch_eff;
      tag_nxt[1] = fetch_col;
      for (int j = 2; j < KS; j++) begin
        sh_nxt[j]  = sh_eff[j-1];
        tag_nxt[j] = tag_r[j-1];
      end
    end else begin
      for (int j = 1; j < KS; j++) begin
        sh_nxt[j]  = sh_eff[j];
        tag_nxt[j] = tag_r[j];
      end
    end
    taps[KS-1] = fetch_eff;
    for (int j = 1; j < KS; j++) begin
      taps[KS-1-j] = ctl.from_shift[j] ? sh_eff[j] : edge_nxt[ctl.edge_idx[j]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit) begin
      mem[wr_col] <= wr_data;
    end
    rd_q <= (ctl.hit && wr_col == rd_addr) ? wr_data : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    for (int j = 1; j < KS; j++) begin
      sh_r[j]  <= sh_nxt[j];
      tag_r[j] <= tag_nxt[j];
    end
    for (int k = 0; k < KR; k++) begin
      edge_r[k] <= edge_nxt[k];
    end
  end

endmodule

@@ sv/log9_sum.sv @@
`timescale 1ns / 1ps
// log9_sum: window capture, row select, weighted row sums, total and the
// output register. Depends on log9_pkg.
module log9_sum #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    adv,
  input  logic                                                    emit,
  input  logic [log9_pkg::KS-1:0][log9_pkg::KS-1:0][log9_pkg::LW-1:0] cell_taps,
  input  logic [log9_pkg::KS-1:0][log9_pkg::SLW-1:0]              sel,
  input  logic [$clog2(MAX_WIDTH)-1:0]                            col,
  input  logic [log9_pkg::RW-1:0]                                 row,
  input  logic                                                    last,
  output logic                                                    out_valid,
  output logic signed [log9_pkg::EW-1:0]                          out_energy,
  output logic [$clog2(MAX_WIDTH)-1:0]                            out_col,
  output logic [log9_pkg::RW-1:0]                                 out_row,
  output logic                                                    out_frame_end
);
  import log9_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic v2_r, v3_r, v4_r, ov_r;
  logic [KS-1:0][KS-1:0][LW-1:0] cv_r;
  logic [KS-1:0][SLW-1:0]        sel_r;
  logic [KS-1:0][KS-1:0][LW-1:0] win_r;
  logic signed [EW-1:0]          rs_r  [KS];
  logic signed [EW-1:0]          rs_nxt[KS];
  logic signed [EW-1:0]          tot_nxt;
  logic [CW-1:0] c2_r, c3_r, c4_r, c5_r;
  logic [RW-1:0] r2_r, r3_r, r4_r, r5_r;
  logic          l2_r, l3_r, l4_r, l5_r;
  logic signed [EW-1:0] e5_r;

  always_comb begin
    for (int dy = 0; dy < KS; dy++) begin
      rs_nxt[dy] = '0;
      for (int dx = 0; dx < KS; dx++) begin
        rs_nxt[dy] = rs_nxt[dy] + weigh(win_r[dy][dx], KERNEL[dy][dx]);
      end
    end
    tot_nxt = ENERGY_OFFSET;
    for (int dy = 0; dy < KS; dy++) begin
      tot_nxt = tot_nxt + rs_r[dy];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v2_r <= emit;
      v3_r <= v2_r;
      v4_r <= v3_r;
      ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cv_r  <= cell_taps;
      sel_r <= sel;
      c2_r  <= col;
      r2_r  <= row;
      l2_r  <= last;
      for (int dy = 0; dy < KS; dy++) begin
        win_r[dy] <= cv_r[sel_r[dy]];
        rs_r[dy]  <= rs_nxt[dy];
      end
      c3_r <= c2_r;
      r3_r <= r2_r;
      l3_r <= l2_r;
      c4_r <= c3_r;
      r4_r <= r3_r;
      l4_r <= l3_r;
      e5_r <= tot_nxt;
      c5_r <= c4_r;
      r5_r <= r4_r;
      l5_r <= l4_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_energy    = e5_r;
  assign out_col       = c5_r;
  assign out_row       = r5_r;
  assign out_frame_end = l5_r;

endmodule

@@ sv/laplacian_of_gaussian_9x9_luma.sv @@
`timescale 1ns / 1ps
// laplacian_of_gaussian_9x9_luma: streaming 9x9 LoG over scaled luma with
// clamp-to-edge borders. Depends on log9_pkg, log9_cell, log9_sum.
// Stages: input, window capture, row select, row sums, output register; results
//   trail pixels by 4*image_width+4 beats, flushed by drain beats.
// Throughput: one beat per clock; the whole pipe holds while the output
//   register is full and stalled, so in_stall follows out_stall in that cycle.
// Reset (sync, active low): counters clear, width 1024, height 768; line
//   memories are not cleared and hold garbage until written.
module laplacian_of_gaussian_9x9_luma #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic [log9_pkg::PW-1:0]             in_red,
  input  logic [log9_pkg::PW-1:0]             in_green,
  input  logic [log9_pkg::PW-1:0]             in_blue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [log9_pkg::EW-1:0]      out_energy,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
  output logic [log9_pkg::RW-1:0]             out_row,
  output logic                                out_frame_end,
  input  logic                                cfg_we,
  input  logic [log9_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [log9_pkg::CFG_W-1:0]          cfg_wdata
);
  import log9_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);       // column index
  localparam int WW   = $clog2(MAX_WIDTH + 1);   // effective width value
  localparam int NW   = WW + HW;                 // pixel counts
  localparam int DLW  = WW + 3;                  // delay and in/out distance
  localparam int WRST = (MAX_WIDTH < W_RESET) ? MAX_WIDTH : W_RESET;

  // ---------------------------------------------------------------------
  // Flow control: one global advance. Everything moves unless the output
  // register holds a beat the consumer is stalling.
  // ---------------------------------------------------------------------
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input stage: luma is formed here and registered with the handshake.
  logic          v0_r;
  logic          cmd0_r;
  logic [LW-1:0] luma0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0_r  <= in_command;
      luma0_r <= luma_of(in_red, in_green, in_blue);
    end
  end

  // ---------------------------------------------------------------------
  // Configuration: the effective (clamped) size is stored directly.
  // ---------------------------------------------------------------------
  logic [WW-1:0] w_eff_r, w_eff_nxt;
  logic [HW-1:0] h_eff_r, h_eff_nxt;
  logic [NW-1:0] npix_r;

  always_comb begin
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_wdata[WRW-1:0] == '0) w_eff_nxt = WW'(1);
          else if (int'(cfg_wdata[WRW-1:0]) > MAX_WIDTH) w_eff_nxt = WW'(MAX_WIDTH);
          else w_eff_nxt = WW'(cfg_wdata[WRW-1:0]);
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_wdata == '0) h_eff_nxt = HW'(1);
          else if (int'(cfg_wdata) > H_MAX) h_eff_nxt = HW'(H_MAX);
          else h_eff_nxt = cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Step control: input/output positions, the ring slot being written and
  // the one being read, and the distance between the two streams.
  // ---------------------------------------------------------------------
  logic [NW-1:0]  in_cnt_r,  in_cnt_nxt,  out_cnt_r, out_cnt_nxt;
  logic [DLW-1:0] diff_r,    diff_nxt,    delay;
  logic [CW-1:0]  in_col_r,  in_col_nxt,  out_col_r, out_col_nxt;
  logic [SLW-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [RW-1:0]  out_row_r, out_row_nxt;
  logic           step, in_done, out_done, we, emit, last, restart;

  assign step     = adv && v0_r;
  assign in_done  = (in_cnt_r == npix_r);
  assign out_done = (out_cnt_r == npix_r);
  assign last     = (NW'(out_cnt_r + NW'(1)) == npix_r);
  assign delay    = (DLW'(w_eff_r) << 2) + DLW'(KR);

  always_comb begin
    we      = 1'b0;
    emit    = 1'b0;
    if (step) begin
      if (!in_done) begin
        // drain beats during the pixel phase are dropped
        if (!cmd0_r) begin
          we   = 1'b1;
          emit = (diff_r + DLW'(1)) > delay;
        end
      end else begin
        // pixels past the frame count as drain beats
        emit = !out_done;
      end
    end
    restart = (step && in_done && out_done) || (emit && last) || cfg_we;

    in_cnt_nxt   = in_cnt_r;
    out_cnt_nxt  = out_cnt_r;
    in_col_nxt   = in_col_r;
    out_col_nxt  = out_col_r;
    in_slot_nxt  = in_slot_r;
    out_slot_nxt = out_slot_r;
    out_row_nxt  = out_row_r;
    diff_nxt     = diff_r + DLW'(we) - DLW'(emit);

    if (we) begin
      in_cnt_nxt = in_cnt_r + NW'(1);
      if (WW'(in_col_r) + WW'(1) >= w_eff_r) begin
        in_col_nxt  = '0;
        in_slot_nxt = slot_add(in_slot_r, 1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
    if (emit) begin
      out_cnt_nxt = out_cnt_r + NW'(1);
      if (WW'(out_col_r) + WW'(1) >= w_eff_r) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + RW'(1);
        out_slot_nxt = slot_add(out_slot_r, 1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
    if (restart) begin
      in_cnt_nxt   = '0;
      out_cnt_nxt  = '0;
      diff_nxt     = '0;
      in_col_nxt   = '0;
      out_col_nxt  = '0;
      in_slot_nxt  = '0;
      out_slot_nxt = '0;
      out_row_nxt  = '0;
    end
  end

  // Fetch column for the next result: rightmost window column, clamped.
  logic [CW-1:0] pf_addr_r, pf_nxt, pf_col_src;
  logic [WW-1:0] pf_w_src;
  logic [WW:0]   pf_t;

  always_comb begin
    pf_col_src = rst_n ? out_col_nxt : '0;
    pf_w_src   = rst_n ? w_eff_nxt : WW'(WRST);
    pf_t       = (WW+1)'(pf_col_src) + (WW+1)'(KR);
    if (pf_t > (WW+1)'(pf_w_src - WW'(1))) pf_nxt = CW'(pf_w_src - WW'(1));
    else pf_nxt = CW'(pf_t);
  end

  always_ff @(posedge clk) begin
    pf_addr_r <= pf_nxt;
    if (!rst_n) begin
      w_eff_r    <= WW'(WRST);
      h_eff_r    <= HW'(H_RESET);
      npix_r     <= NW'(WRST * H_RESET);
      in_cnt_r   <= '0;
      out_cnt_r  <= '0;
      diff_r     <= '0;
      in_col_r   <= '0;
      out_col_r  <= '0;
      in_slot_r  <= '0;
      out_slot_r <= '0;
      out_row_r  <= '0;
    end else begin
      w_eff_r    <= w_eff_nxt;
      h_eff_r    <= h_eff_nxt;
      npix_r     <= NW'(w_eff_r) * NW'(h_eff_r);
      in_cnt_r   <= in_cnt_nxt;
      out_cnt_r  <= out_cnt_nxt;
      diff_r     <= diff_nxt;
      in_col_r   <= in_col_nxt;
      out_col_r  <= out_col_nxt;
      in_slot_r  <= in_slot_nxt;
      out_slot_r <= out_slot_nxt;
      out_row_r  <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Window column selection, shared by all cells. Tap j (j results back)
  // is on the shift line only if that fetch was made in this output row;
  // otherwise it is a clamped left-edge column, held in the edge cache.
  // ---------------------------------------------------------------------
  logic [KS-1:1]          tap_from_shift;
  logic [KS-1:1][EIW-1:0] tap_edge_idx;
  logic [KS-1:0][SLW-1:0] row_sel;

  always_comb begin
    int v;
    int rr;
    for (int j = 1; j < KS; j++) begin
      tap_from_shift[j] = (int'(out_col_r) >= j);
      v = int'(out_col_r) - j + KR;
      if (v < 0) v = 0;
      if (v > int'(w_eff_r) - 1) v = int'(w_eff_r) - 1;
      tap_edge_idx[j] = EIW'(v);
    end
    // ring slot of each window row, clamped to the frame top and bottom
    for (int dy = 0; dy < KS; dy++) begin
      rr = int'(out_row_r) + dy - KR;
      if (rr < 0) row_sel[dy] = '0;
      else if (rr > int'(h_eff_r) - 1)
        row_sel[dy] = slot_add(out_slot_r, int'(h_eff_r) - 1 - int'(out_row_r));
      else row_sel[dy] = slot_add(out_slot_r, dy - KR);
    end
  end

  // ---------------------------------------------------------------------
  // Row of cells, one per ring slot of the line store.
  // ---------------------------------------------------------------------
  logic [KS-1:0][KS-1:0][LW-1:0] cell_taps;

  for (genvar i = 0; i < KS; i++) begin : g_cell
    cell_ctl_t ctl;
    always_comb begin
      ctl.hit        = we && (in_slot_r == SLW'(i));
      ctl.emit       = emit;
      ctl.from_shift = tap_from_shift;
      ctl.edge_idx   = tap_edge_idx;
    end
    log9_cell #(.MAX_WIDTH(MAX_WIDTH)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wr_col    (in_col_r),
      .wr_data   (luma0_r),
      .fetch_col (pf_addr_r),
      .rd_addr   (pf_nxt),
      .taps      (cell_taps[i])
    );
  end

  // ---------------------------------------------------------------------
  // Kernel sum and output register.
  // ---------------------------------------------------------------------
  log9_sum #(.MAX_WIDTH(MAX_WIDTH)) u_sum (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .emit          (emit),
    .cell_taps     (cell_taps),
    .sel           (row_sel),
    .col           (out_col_r),
    .row           (out_row_r),
    .last          (last),
    .out_valid     (out_valid),
    .out_energy    (out_energy),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_frame_end (out_frame_end)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= in_cnt_r)
    else $error("result count passed pixel count");

  a_diff_track: assert property (@(posedge clk) disable iff (!rst_n)
    diff_r == DLW'(in_cnt_r - out_cnt_r))
    else $error("stream distance out of step with counters");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |->
      (out_col == CW'(w_eff_r - WW'(1)) && out_row == RW'(h_eff_r - HW'(1))))
    else $error("frame end not on the last pixel");

endmodule
